// ===== sv/bsp_pkg.sv =====
// Shared types and constants for the billboard sprite projector.
package bsp_pkg;

    localparam int TEX_W_DEF      = 64;
    localparam int TEX_H_DEF      = 64;
    localparam int MAX_SCREEN_DEF = 4096;
    localparam int STORE_DEPTH    = 4096;
    localparam int STORE_AW       = 12;
    localparam int DVD_W          = 65;
    localparam int DVS_W          = 48;
    localparam int COORD_MAX      = 65535;

    localparam logic [2:0] CFG_VIEWER_X = 3'd0;
    localparam logic [2:0] CFG_VIEWER_Y = 3'd1;
    localparam logic [2:0] CFG_FACING_X = 3'd2;
    localparam logic [2:0] CFG_FACING_Y = 3'd3;
    localparam logic [2:0] CFG_LENS_X   = 3'd4;
    localparam logic [2:0] CFG_LENS_Y   = 3'd5;
    localparam logic [2:0] CFG_SCR_W    = 3'd6;
    localparam logic [2:0] CFG_SCR_H    = 3'd7;

    localparam logic [1:0] REQ_PROJECT = 2'd0;
    localparam logic [1:0] REQ_PIXEL   = 2'd1;
    localparam logic [1:0] REQ_TEXEL   = 2'd2;

    localparam logic signed [31:0] RST_FACING_X = -32'sd65536;
    localparam logic signed [31:0] RST_LENS_Y   = 32'sd43253;
    localparam logic [12:0]        RST_SCR_W    = 13'd640;
    localparam logic [12:0]        RST_SCR_H    = 13'd480;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DQ,
        ST_DIVX,
        ST_DIVY,
        ST_DIVR,
        ST_CPROD,
        ST_CTR,
        ST_DIVS,
        ST_BOUND,
        ST_PXDIVU,
        ST_PXDIVT,
        ST_RD,
        ST_PXOUT,
        ST_TLOAD,
        ST_OUT
    } t_state;

endpackage

// ===== sv/bsp_div.sv =====
// Shared restoring radix-2 unsigned divider, one quotient bit per cycle.
module bsp_div #(
    parameter int DVD_W = bsp_pkg::DVD_W,
    parameter int DVS_W = bsp_pkg::DVS_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);
    localparam int CW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   rem_sh;
    logic             fits;

    always_comb begin
        rem_sh = {r_rem, r_q[DVD_W-1]};
        fits   = rem_sh >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= DVS_W'(rem_sh - {1'b0, r_dvs});
            end else begin
                r_rem <= rem_sh[DVS_W-1:0];
            end
            r_q <= {r_q[DVD_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

// ===== sv/billboard_sprite_projector_core.sv =====
// Billboard sprite projector: camera transform, sprite rectangle and pixel shading.
//
// Input word on s_axis: tuser carries the request kind (project, pixel, texel
// load), tdata the sprite position, pixel column/row, wall depth and texel
// address/value. Every request returns exactly one word on m_axis holding the
// stored projection (centre, left/right/top/bottom bounds) and the pixel
// result (texel column/row, color, write flag).
// Configuration is a write-only register port (viewer, facing, lens, screen
// size); the user must write it only while the block is idle, which the
// block itself does not enforce. One request is in flight at a time;
// s_axis_tready is high only when idle. All divisions go through one shared
// 65-step radix-2 divider: a project request uses six multiplies plus up to
// four divisions, a pixel request inside the rectangle up to two divisions
// and a texture read, a pixel request outside it no division, and a texel
// load a single write to the texture store.
// The result word holds until m_axis_tready; no new word is taken meanwhile.
// Reset restores the register defaults and clears the stored projection; the
// texture store is not cleared and must be loaded before it is read.
module billboard_sprite_projector_core #(
    parameter int TEXTURE_WIDTH  = bsp_pkg::TEX_W_DEF,
    parameter int TEXTURE_HEIGHT = bsp_pkg::TEX_H_DEF,
    parameter int MAX_SCREEN     = bsp_pkg::MAX_SCREEN_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // sprite_pos_x[31:0], sprite_pos_y, pixel_column, pixel_row, wall_depth,
    // texel_address, texel_value, zero pad
    input  logic [167:0] i_s_axis_tdata,
    // req_type
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // center_column[16:0], left_edge, right_edge, top_edge, bottom_edge,
    // texel_col, texel_row, pixel_color, pixel_write
    output logic [127:0] o_m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata
);
    localparam int DW = bsp_pkg::DVD_W;
    localparam int VW = bsp_pkg::DVS_W;

    // configuration
    logic signed [31:0] r_vx, r_vy, r_fx, r_fy, r_lx, r_ly;
    logic [12:0]        r_sw, r_sh;

    // stored projection
    logic signed [31:0] r_ty;
    logic signed [16:0] r_ctr;
    logic [15:0]        r_size;
    logic [15:0]        r_left, r_top;
    logic signed [16:0] r_right, r_bot;

    // work registers
    bsp_pkg::t_state    r_state, n_state;
    logic [2:0]         r_k;
    logic               r_issued;
    logic signed [31:0] r_dx, r_dy, r_z, r_tx;
    logic [11:0]        r_col, r_row, r_taddr;
    logic [31:0]        r_tval;
    logic signed [63:0] r_prod;
    logic signed [64:0] r_det, r_nx, r_ny;
    logic signed [48:0] r_dq;
    logic signed [48:0] r_r;
    logic signed [62:0] r_cp;
    logic               r_dsign;
    logic [7:0]         r_u, r_t;
    logic [31:0]        r_rd;
    logic [5:0]         r_o_tcol, r_o_trow;
    logic [31:0]        r_o_color;
    logic               r_o_wr;

    logic [31:0] mem [bsp_pkg::STORE_DEPTH];

    // input fields
    logic signed [31:0] f_sx, f_sy, f_z;
    logic [11:0]        f_col, f_row, f_taddr;
    logic [31:0]        f_tval;
    logic [1:0]         f_req;
    logic               s_acc;

    assign f_sx    = i_s_axis_tdata[31:0];
    assign f_sy    = i_s_axis_tdata[63:32];
    assign f_col   = i_s_axis_tdata[75:64];
    assign f_row   = i_s_axis_tdata[87:76];
    assign f_z     = i_s_axis_tdata[119:88];
    assign f_taddr = i_s_axis_tdata[131:120];
    assign f_tval  = i_s_axis_tdata[163:132];
    assign f_req   = i_s_axis_tuser;
    assign s_acc   = i_s_axis_tvalid && o_s_axis_tready;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
        if (v > 66'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -66'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // screen size used
    logic [12:0] w_use, h_use;
    always_comb begin
        w_use = (32'(r_sw) > MAX_SCREEN) ? 13'(MAX_SCREEN) : r_sw;
        h_use = (32'(r_sh) > MAX_SCREEN) ? 13'(MAX_SCREEN) : r_sh;
    end

    // shared multiplier
    logic signed [31:0] m_a, m_b;
    logic signed [63:0] m_p;
    always_comb begin
        unique case (r_k)
            3'd0:    begin m_a = r_lx; m_b = r_fy; end
            3'd1:    begin m_a = r_fx; m_b = r_ly; end
            3'd2:    begin m_a = r_fy; m_b = r_dx; end
            3'd3:    begin m_a = r_fx; m_b = r_dy; end
            3'd4:    begin m_a = r_lx; m_b = r_dy; end
            3'd5:    begin m_a = r_ly; m_b = r_dx; end
            default: begin m_a = r_lx; m_b = r_fy; end
        endcase
        m_p = m_a * m_b;
    end

    // derived values
    logic signed [64:0] det_adj;
    logic signed [48:0] dq_c;
    logic [DW-1:0]      abs_nx, abs_ny;
    logic [47:0]        abs_dq;
    logic [31:0]        abs_tx, abs_ty;
    logic signed [49:0] s50;
    logic signed [62:0] cp_c;
    logic signed [62:0] cp_adj;
    logic signed [46:0] ctr_w;
    logic signed [18:0] ctr19, half19, hh19, w19, h19, c19;
    logic signed [18:0] v_l, v_r, v_t, v_b;
    logic [16:0]        diff17;
    logic signed [26:0] d27;
    logic [16:0]        addr17;

    always_comb begin
        det_adj = r_det + (r_det[64] ? 65'sd65535 : 65'sd0);
        dq_c    = 49'(det_adj >>> 16);
        abs_nx  = r_nx[64] ? DW'(-r_nx) : DW'(r_nx);
        abs_ny  = r_ny[64] ? DW'(-r_ny) : DW'(r_ny);
        abs_dq  = r_dq[48] ? 48'(-r_dq) : 48'(r_dq);
        abs_tx  = r_tx[31] ? 32'(-r_tx) : 32'(r_tx);
        abs_ty  = r_ty[31] ? 32'(-r_ty) : 32'(r_ty);
        s50     = 50'sd65536 + 50'(r_r);
        cp_c    = $signed({1'b0, w_use[12:1]}) * s50;
        cp_adj  = r_cp + (r_cp[62] ? 63'sd65535 : 63'sd0);
        ctr_w   = 47'(cp_adj >>> 16);
        ctr19   = 19'(r_ctr);
        half19  = $signed({4'b0, r_size[15:1]});
        hh19    = $signed({7'b0, h_use[12:1]});
        w19     = $signed({6'b0, w_use});
        h19     = $signed({6'b0, h_use});
        c19     = $signed({7'b0, r_col});
        v_l     = ctr19 - half19;
        v_r     = half19 + ctr19;
        v_t     = hh19 - half19;
        v_b     = half19 + hh19;
        diff17  = 17'(c19 - ctr19 + half19);
        d27     = 27'({r_row, 8'b0}) - 27'({h_use, 7'b0}) + 27'({r_size, 7'b0});
        addr17  = 17'(TEXTURE_WIDTH) * 17'(r_t) + 17'(r_u);
    end

    // pixel rectangle test on the incoming word
    logic px_in;
    always_comb begin
        px_in = ({4'b0, f_col} >= r_left)
             && ($signed({6'b0, f_col}) < 18'(r_right))
             && ({4'b0, f_row} >= r_top)
             && ($signed({6'b0, f_row}) < 18'(r_bot))
             && (r_size != 16'd0);
    end

    // divider
    logic          div_start, div_done, dsign_c;
    logic [DW-1:0] div_dvd, div_q;
    logic [VW-1:0] div_dvs;
    logic signed [65:0] q_s;

    always_comb begin
        div_dvd = '0;
        div_dvs = '0;
        dsign_c = 1'b0;
        unique case (r_state)
            bsp_pkg::ST_DIVX: begin
                div_dvd = abs_nx;
                div_dvs = abs_dq;
                dsign_c = r_nx[64] ^ r_dq[48];
            end
            bsp_pkg::ST_DIVY: begin
                div_dvd = abs_ny;
                div_dvs = abs_dq;
                dsign_c = r_ny[64] ^ r_dq[48];
            end
            bsp_pkg::ST_DIVR: begin
                div_dvd = DW'({abs_tx, 16'b0});
                div_dvs = VW'(abs_ty);
                dsign_c = r_tx[31] ^ r_ty[31];
            end
            bsp_pkg::ST_DIVS: begin
                div_dvd = DW'({h_use, 16'b0});
                div_dvs = VW'(abs_ty);
            end
            bsp_pkg::ST_PXDIVU: begin
                div_dvd = (DW'(diff17) * DW'(TEXTURE_WIDTH)) << 8;
                div_dvs = VW'(r_size);
            end
            bsp_pkg::ST_PXDIVT: begin
                div_dvd = DW'(d27[25:0]) * DW'(TEXTURE_HEIGHT);
                div_dvs = VW'(r_size);
            end
            default: ;
        endcase
        q_s = r_dsign ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    end

    assign div_start = !r_issued && (r_state == bsp_pkg::ST_DIVX
        || r_state == bsp_pkg::ST_DIVY || r_state == bsp_pkg::ST_DIVR
        || r_state == bsp_pkg::ST_DIVS || r_state == bsp_pkg::ST_PXDIVU
        || r_state == bsp_pkg::ST_PXDIVT);

    bsp_div #(
        .DVD_W (DW),
        .DVS_W (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bsp_pkg::ST_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) begin
                r_issued <= 1'b0;
            end else if (div_start) begin
                r_issued <= 1'b1;
            end
        end
    end

    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;
        unique case (r_state)
            bsp_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    unique case (f_req)
                        bsp_pkg::REQ_PROJECT: n_state = bsp_pkg::ST_MUL;
                        bsp_pkg::REQ_PIXEL:
                            n_state = px_in ? bsp_pkg::ST_PXDIVU : bsp_pkg::ST_OUT;
                        bsp_pkg::REQ_TEXEL:   n_state = bsp_pkg::ST_TLOAD;
                        default:              n_state = bsp_pkg::ST_OUT;
                    endcase
                end
            end
            bsp_pkg::ST_MUL:
                if (r_k == 3'd6) n_state = bsp_pkg::ST_DQ;
            bsp_pkg::ST_DQ:
                n_state = (dq_c == 49'sd0) ? bsp_pkg::ST_CPROD : bsp_pkg::ST_DIVX;
            bsp_pkg::ST_DIVX:
                if (div_done) n_state = bsp_pkg::ST_DIVY;
            bsp_pkg::ST_DIVY:
                if (div_done) begin
                    n_state = (sat66(q_s) == 32'sd0) ? bsp_pkg::ST_CPROD
                                                     : bsp_pkg::ST_DIVR;
                end
            bsp_pkg::ST_DIVR:
                if (div_done) n_state = bsp_pkg::ST_CPROD;
            bsp_pkg::ST_CPROD: n_state = bsp_pkg::ST_CTR;
            bsp_pkg::ST_CTR:
                n_state = (r_ty == 32'sd0) ? bsp_pkg::ST_BOUND : bsp_pkg::ST_DIVS;
            bsp_pkg::ST_DIVS:
                if (div_done) n_state = bsp_pkg::ST_BOUND;
            bsp_pkg::ST_BOUND: n_state = bsp_pkg::ST_OUT;
            bsp_pkg::ST_PXDIVU:
                if (div_done) begin
                    n_state = d27[26] ? bsp_pkg::ST_RD : bsp_pkg::ST_PXDIVT;
                end
            bsp_pkg::ST_PXDIVT:
                if (div_done) n_state = bsp_pkg::ST_RD;
            bsp_pkg::ST_RD:    n_state = bsp_pkg::ST_PXOUT;
            bsp_pkg::ST_PXOUT: n_state = bsp_pkg::ST_OUT;
            bsp_pkg::ST_TLOAD: n_state = bsp_pkg::ST_OUT;
            bsp_pkg::ST_OUT: begin
                o_m_axis_tvalid = 1'b1;
                if (i_m_axis_tready) n_state = bsp_pkg::ST_IDLE;
            end
            default: n_state = bsp_pkg::ST_IDLE;
        endcase
    end

    // configuration and stored projection
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx    <= '0;
            r_vy    <= '0;
            r_fx    <= bsp_pkg::RST_FACING_X;
            r_fy    <= '0;
            r_lx    <= '0;
            r_ly    <= bsp_pkg::RST_LENS_Y;
            r_sw    <= bsp_pkg::RST_SCR_W;
            r_sh    <= bsp_pkg::RST_SCR_H;
            r_ty    <= '0;
            r_ctr   <= '0;
            r_size  <= '0;
            r_left  <= '0;
            r_right <= '0;
            r_top   <= '0;
            r_bot   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    bsp_pkg::CFG_VIEWER_X: r_vx <= i_cfg_wdata;
                    bsp_pkg::CFG_VIEWER_Y: r_vy <= i_cfg_wdata;
                    bsp_pkg::CFG_FACING_X: r_fx <= i_cfg_wdata;
                    bsp_pkg::CFG_FACING_Y: r_fy <= i_cfg_wdata;
                    bsp_pkg::CFG_LENS_X:   r_lx <= i_cfg_wdata;
                    bsp_pkg::CFG_LENS_Y:   r_ly <= i_cfg_wdata;
                    bsp_pkg::CFG_SCR_W:    r_sw <= i_cfg_wdata[12:0];
                    bsp_pkg::CFG_SCR_H:    r_sh <= i_cfg_wdata[12:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                bsp_pkg::ST_DQ:
                    if (dq_c == 49'sd0) r_ty <= '0;
                bsp_pkg::ST_DIVY:
                    if (div_done) r_ty <= sat66(q_s);
                bsp_pkg::ST_CTR: begin
                    if (ctr_w > 47'sd65535) begin
                        r_ctr <= 17'sd65535;
                    end else if (ctr_w < -47'sd65535) begin
                        r_ctr <= -17'sd65535;
                    end else begin
                        r_ctr <= ctr_w[16:0];
                    end
                    if (r_ty == 32'sd0) r_size <= 16'(bsp_pkg::COORD_MAX);
                end
                bsp_pkg::ST_DIVS:
                    if (div_done) begin
                        r_size <= (div_q > DW'(bsp_pkg::COORD_MAX))
                                ? 16'(bsp_pkg::COORD_MAX) : div_q[15:0];
                    end
                bsp_pkg::ST_BOUND: begin
                    r_left  <= v_l[18] ? 16'd0 : v_l[15:0];
                    r_right <= (v_r >= w19) ? 17'(w19 - 19'sd1) : v_r[16:0];
                    r_top   <= v_t[18] ? 16'd0 : v_t[15:0];
                    r_bot   <= (v_b >= h19) ? 17'(h19 - 19'sd1) : v_b[16:0];
                end
                default: ;
            endcase
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (r_state == bsp_pkg::ST_MUL) begin
            r_k <= r_k + 1'b1;
        end else begin
            r_k <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_dx    <= sat33(33'(f_sx) - 33'(r_vx));
            r_dy    <= sat33(33'(f_sy) - 33'(r_vy));
            r_col   <= f_col;
            r_row   <= f_row;
            r_z     <= f_z;
            r_taddr <= f_taddr;
            r_tval  <= f_tval;
            r_o_tcol  <= '0;
            r_o_trow  <= '0;
            r_o_color <= '0;
            r_o_wr    <= 1'b0;
        end
        if (div_start) r_dsign <= dsign_c;
        unique case (r_state)
            bsp_pkg::ST_MUL: begin
                r_prod <= m_p;
                unique case (r_k)
                    3'd1:    r_det <= 65'(r_prod);
                    3'd2:    r_det <= r_det - 65'(r_prod);
                    3'd3:    r_nx  <= 65'(r_prod);
                    3'd4:    r_nx  <= r_nx - 65'(r_prod);
                    3'd5:    r_ny  <= 65'(r_prod);
                    3'd6:    r_ny  <= r_ny - 65'(r_prod);
                    default: ;
                endcase
            end
            bsp_pkg::ST_DQ: begin
                r_dq <= dq_c;
                r_r  <= '0;
                r_tx <= '0;
            end
            bsp_pkg::ST_DIVX:
                if (div_done) r_tx <= sat66(q_s);
            bsp_pkg::ST_DIVY:
                if (div_done) r_r <= '0;
            bsp_pkg::ST_DIVR:
                if (div_done) r_r <= 49'(q_s);
            bsp_pkg::ST_CPROD: r_cp <= cp_c;
            bsp_pkg::ST_PXDIVU:
                if (div_done) begin
                    r_u <= (div_q[DW-1:8] > (DW-8)'(TEXTURE_WIDTH - 1))
                         ? 8'(TEXTURE_WIDTH - 1) : div_q[15:8];
                    r_t <= '0;
                end
            bsp_pkg::ST_PXDIVT:
                if (div_done) begin
                    r_t <= (div_q[DW-1:8] > (DW-8)'(TEXTURE_HEIGHT - 1))
                         ? 8'(TEXTURE_HEIGHT - 1) : div_q[15:8];
                end
            bsp_pkg::ST_PXOUT: begin
                r_o_tcol  <= r_u[5:0];
                r_o_trow  <= r_t[5:0];
                r_o_color <= r_rd;
                r_o_wr    <= (r_ty > 32'sd0) && (r_col != 12'd0)
                          && ({1'b0, r_col} < w_use) && (r_ty < r_z)
                          && (r_rd[23:0] != 24'd0);
            end
            default: ;
        endcase
    end

    // texture store
    always_ff @(posedge i_clk) begin
        if (r_state == bsp_pkg::ST_TLOAD) begin
            mem[r_taddr] <= r_tval;
        end
        if (r_state == bsp_pkg::ST_RD) begin
            r_rd <= mem[addr17[bsp_pkg::STORE_AW-1:0]];
        end
    end

    assign o_m_axis_tdata = {r_o_wr, r_o_color, r_o_trow, r_o_tcol,
                             r_bot, r_top, r_right, r_left, r_ctr};
endmodule

// ===== bench/tb_billboard_sprite_projector_core.sv =====
// Self-checking bench for the billboard sprite projector core.
module tb_billboard_sprite_projector_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TEX_W = 64;
    localparam int TEX_H = 64;

    typedef struct packed {
        logic               pix_wr;
        logic [31:0]        color;
        logic [5:0]         trow;
        logic [5:0]         tcol;
        logic signed [16:0] bottom;
        logic [15:0]        top;
        logic signed [16:0] right;
        logic [15:0]        left;
        logic signed [16:0] center;
    } t_proj_word;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [167:0] i_s_axis_tdata = '0;
    logic [1:0]   i_s_axis_tuser = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [127:0] o_m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_addr = '0;
    logic [31:0]  i_cfg_wdata = '0;

    billboard_sprite_projector_core u_dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    longint cam_vx, cam_vy, cam_fx, cam_fy, cam_lx, cam_ly, scr_w, scr_h;
    longint view_depth, ctr_col, spr_tall, spr_wide;
    longint rect[4];
    logic [31:0] tex_mem[4096];
    bit          tex_valid[4096];

    t_proj_word expected_words[$];
    int         mismatches = 0;
    bit         sink_quiet = 0;
    bit         src_quiet = 0;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint sat32(longint v);
        return clip(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic void camera_reset();
        cam_vx = 0; cam_vy = 0; cam_fx = -65536; cam_fy = 0;
        cam_lx = 0; cam_ly = 43253; scr_w = 640; scr_h = 480;
        view_depth = 0; ctr_col = 0; spr_tall = 0; spr_wide = 0;
        foreach (rect[i]) rect[i] = 0;
    endfunction

    function automatic void project_sprite(longint sx, longint sy);
        longint w, h, dx, dy, det, dq, tx, ty, r, sz, c, v;
        w = clip(scr_w, 0, bsp_pkg::MAX_SCREEN_DEF);
        h = clip(scr_h, 0, bsp_pkg::MAX_SCREEN_DEF);
        dx = sat32(sx - cam_vx);
        dy = sat32(sy - cam_vy);
        det = cam_lx * cam_fy - cam_fx * cam_ly;
        dq = det / 65536;
        tx = 0; ty = 0; r = 0;
        if (dq != 0) begin
            tx = sat32((cam_fy * dx - cam_fx * dy) / dq);
            ty = sat32((cam_lx * dy - cam_ly * dx) / dq);
        end
        if (ty != 0) r = (tx * 65536) / ty;
        c = clip(((w / 2) * (65536 + r)) / 65536, -bsp_pkg::COORD_MAX, bsp_pkg::COORD_MAX);
        if (ty == 0) sz = bsp_pkg::COORD_MAX;
        else sz = clip((h * 65536) / (ty < 0 ? -ty : ty), 0, bsp_pkg::COORD_MAX);
        view_depth = ty; ctr_col = c; spr_tall = sz; spr_wide = sz;
        v = c - sz / 2;       rect[0] = v < 0 ? 0 : v;
        v = sz / 2 + c;       rect[1] = v >= w ? w - 1 : v;
        v = h / 2 - sz / 2;   rect[2] = v < 0 ? 0 : v;
        v = sz / 2 + h / 2;   rect[3] = v >= h ? h - 1 : v;
    endfunction

    // address a pixel request would read, or -1 when outside the rectangle
    function automatic int pixel_addr(longint c, longint y);
        longint h, u, d, t;
        h = clip(scr_h, 0, bsp_pkg::MAX_SCREEN_DEF);
        if (!(c >= rect[0] && c < rect[1] && y >= rect[2] && y < rect[3] &&
              spr_wide > 0 && spr_tall > 0))
            return -1;
        u = clip((256 * (c - (ctr_col - spr_wide / 2)) * TEX_W / spr_wide) / 256,
                 0, TEX_W - 1);
        d = y * 256 - h * 128 + spr_tall * 128;
        t = clip(((d * TEX_H) / spr_tall) / 256, 0, TEX_H - 1);
        return int'((TEX_W * t + u) & 12'hFFF);
    endfunction

    function automatic t_proj_word shade_and_echo(logic [1:0] kind, logic [167:0] d);
        t_proj_word e;
        longint c, y, z, w;
        int a;
        e = '0;
        if (kind == bsp_pkg::REQ_PROJECT) begin
            project_sprite(longint'($signed(d[31:0])), longint'($signed(d[63:32])));
        end else if (kind == bsp_pkg::REQ_PIXEL) begin
            c = d[75:64];
            y = d[87:76];
            z = longint'($signed(d[119:88]));
            w = clip(scr_w, 0, bsp_pkg::MAX_SCREEN_DEF);
            a = pixel_addr(c, y);
            if (a >= 0) begin
                e.tcol = a[5:0];
                e.trow = a[11:6];
                e.color = tex_mem[a];
                e.pix_wr = view_depth > 0 && c > 0 && c < w && view_depth < z &&
                           (tex_mem[a] & 32'h00FF_FFFF) != 0;
            end
        end else if (kind == bsp_pkg::REQ_TEXEL) begin
            tex_mem[d[131:120]] = d[163:132];
            tex_valid[d[131:120]] = 1;
        end
        e.center = ctr_col[16:0];
        e.left = rect[0][15:0];
        e.right = rect[1][16:0];
        e.top = rect[2][15:0];
        e.bottom = rect[3][16:0];
        return e;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("mismatch %s: got %0h expected %0h", what, got, want);
    endtask

    task automatic send_word(logic [1:0] kind, logic [167:0] d);
        if (!src_quiet) begin
            while ($urandom_range(99) < 8) @(negedge i_clk);
        end
        i_s_axis_tuser = kind;
        i_s_axis_tdata = d;
        i_s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_words.push_back(shade_and_echo(kind, d));
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_addr = idx;
        i_cfg_wdata = val;
        i_cfg_we = 1'b1;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            bsp_pkg::CFG_VIEWER_X: cam_vx = longint'($signed(val));
            bsp_pkg::CFG_VIEWER_Y: cam_vy = longint'($signed(val));
            bsp_pkg::CFG_FACING_X: cam_fx = longint'($signed(val));
            bsp_pkg::CFG_FACING_Y: cam_fy = longint'($signed(val));
            bsp_pkg::CFG_LENS_X:   cam_lx = longint'($signed(val));
            bsp_pkg::CFG_LENS_Y:   cam_ly = longint'($signed(val));
            bsp_pkg::CFG_SCR_W:    scr_w = val[12:0];
            default:               scr_h = val[12:0];
        endcase
    endtask

    function automatic logic [167:0] pack_in(logic [31:0] px, logic [31:0] py,
            logic [11:0] col, logic [11:0] row, logic [31:0] depth,
            logic [11:0] addr, logic [31:0] val);
        return {4'b0, val, addr, depth, row, col, py, px};
    endfunction

    task automatic send_project(logic [31:0] px, logic [31:0] py);
        send_word(bsp_pkg::REQ_PROJECT, pack_in(px, py, 0, 0, 0, 0, 0));
    endtask

    // pixel request; an unwritten texel it would read is loaded first
    task automatic send_pixel(logic [11:0] col, logic [11:0] row, logic [31:0] depth);
        int a;
        a = pixel_addr(col, row);
        if (a >= 0 && !tex_valid[a]) begin
            send_word(bsp_pkg::REQ_TEXEL, pack_in(0, 0, 0, 0, 0, a[11:0], $urandom));
        end
        send_word(bsp_pkg::REQ_PIXEL, pack_in($urandom, $urandom, col, row, depth,
                                              12'($urandom), $urandom));
    endtask

    task automatic load_texture();
        for (int i = 0; i < TEX_W * TEX_H; i += 64)
            send_word(bsp_pkg::REQ_TEXEL, pack_in(0, 0, 0, 0, 0, i[11:0],
                      (i % 128 == 0) ? 32'hFF00_0000 : $urandom));
    endtask

    task automatic test_reset_defaults();
        send_word(bsp_pkg::REQ_PIXEL, pack_in(0, 0, 12'd100, 12'd100, 32'd65536, 0, 0));
        send_project(32'sd0, 32'sd0);
        send_project(32'h0005_0000, 32'h0001_0000);
    endtask

    task automatic test_directed();
        load_texture();
        send_project(32'h7FFF_FFFF, 32'h8000_0000);
        send_project(32'h8000_0000, 32'h7FFF_FFFF);
        send_project(32'hFFFF_0000, 32'h0000_8000);
        send_pixel(12'd0, 12'd240, 32'h7FFF_FFFF);
        send_pixel(12'd320, 12'd240, 32'h7FFF_FFFF);
        send_pixel(12'd320, 12'd240, 32'h8000_0000);
        send_pixel(12'hFFF, 12'hFFF, 32'h0001_0000);
        send_word(2'd3, {168{1'b1}});
        send_word(bsp_pkg::REQ_TEXEL, pack_in(0, 0, 0, 0, 0, 12'hFFF, 32'hFFFF_FFFF));
        send_word(bsp_pkg::REQ_TEXEL, pack_in(0, 0, 0, 0, 0, 12'h0, 32'h0000_0000));
        drain();
        // degenerate camera: zero lens
        write_reg(bsp_pkg::CFG_LENS_Y, 32'd0);
        send_project(32'h0004_0000, 32'h0);
        send_pixel(12'd10, 12'd10, 32'h7FFF_FFFF);
        drain();
        // oversized and zero screen
        write_reg(bsp_pkg::CFG_LENS_Y, 32'd43253);
        write_reg(bsp_pkg::CFG_SCR_W, 32'h1FFF);
        write_reg(bsp_pkg::CFG_SCR_H, 32'd0);
        send_project(32'hFFFE_0000, 32'h0);
        send_pixel(12'd2048, 12'd0, 32'h7FFF_FFFF);
        drain();
        write_reg(bsp_pkg::CFG_SCR_W, 32'd0);
        write_reg(bsp_pkg::CFG_SCR_H, 32'h1FFF);
        send_project(32'hFFFE_0000, 32'h0);
        drain();
    endtask

    task automatic random_phase(int n, bit wild);
        int k;
        logic [11:0] col, row;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(9);
            if (k < 2 || wild && k == 2) begin
                if (wild) send_project($urandom, $urandom);
                else send_project(32'(cam_vx + cam_fx * $urandom_range(1, 8) +
                                      $signed($urandom_range(0, 131072)) - 65536),
                                  32'(cam_vy + cam_fy * $urandom_range(1, 8) +
                                      $signed($urandom_range(0, 131072)) - 65536));
            end else if (k < 8) begin
                col = (rect[1] > rect[0] && $urandom_range(3) != 0) ?
                      12'($urandom_range(32'(rect[0]), 32'(rect[1]))) : 12'($urandom);
                row = (rect[3] > rect[2] && $urandom_range(3) != 0) ?
                      12'($urandom_range(32'(rect[2]), 32'(rect[3]))) : 12'($urandom);
                send_pixel(col, row, $urandom_range(1) ? $urandom : $urandom_range(0, 1 << 22));
            end else if (k == 8) begin
                send_word(bsp_pkg::REQ_TEXEL, pack_in($urandom, $urandom, 12'($urandom),
                          12'($urandom), $urandom, 12'($urandom), $urandom));
            end else begin
                send_word(2'd3, 168'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                      $urandom}));
            end
        end
        drain();
    endtask

    task automatic test_random_cameras();
        int sw[4] = '{1, 4096, 320, 8191};
        random_phase(80, 0);
        for (int p = 0; p < 4; p++) begin
            write_reg(bsp_pkg::CFG_VIEWER_X, $urandom_range(0, 1 << 22));
            write_reg(bsp_pkg::CFG_VIEWER_Y, $urandom_range(0, 1 << 22));
            write_reg(bsp_pkg::CFG_FACING_X,
                      p == 3 ? 32'h7FFF_FFFF : $signed($urandom_range(0, 131072)) - 65536);
            write_reg(bsp_pkg::CFG_FACING_Y,
                      p == 3 ? 32'h8000_0000 : $signed($urandom_range(0, 131072)) - 65536);
            write_reg(bsp_pkg::CFG_LENS_X,
                      p == 3 ? 32'h8000_0000 : $signed($urandom_range(0, 86506)) - 43253);
            write_reg(bsp_pkg::CFG_LENS_Y,
                      p == 3 ? 32'h7FFF_FFFF : $signed($urandom_range(0, 86506)) - 43253);
            write_reg(bsp_pkg::CFG_SCR_W, sw[p]);
            write_reg(bsp_pkg::CFG_SCR_H, sw[3 - p]);
            random_phase(80, p == 3);
        end
    endtask

    task automatic test_no_stalls();
        write_reg(bsp_pkg::CFG_SCR_W, 32'd640);
        write_reg(bsp_pkg::CFG_SCR_H, 32'd480);
        sink_quiet = 1;
        src_quiet = 1;
        random_phase(40, 0);
        sink_quiet = 0;
        src_quiet = 0;
    endtask

    // result checker and sink backpressure
    always @(negedge i_clk) begin
        i_m_axis_tready <= sink_quiet || $urandom_range(99) >= 8;
    end

    always @(posedge i_clk) begin
        t_proj_word got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_proj_word'(o_m_axis_tdata);
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", o_m_axis_tdata[63:0], 0);
            end else begin
                want = expected_words.pop_front();
                if (got.center !== want.center) report_mismatch("center", got.center, want.center);
                if (got.left !== want.left) report_mismatch("left", got.left, want.left);
                if (got.right !== want.right) report_mismatch("right", got.right, want.right);
                if (got.top !== want.top) report_mismatch("top", got.top, want.top);
                if (got.bottom !== want.bottom) report_mismatch("bottom", got.bottom, want.bottom);
                if (got.tcol !== want.tcol) report_mismatch("texel_col", got.tcol, want.tcol);
                if (got.trow !== want.trow) report_mismatch("texel_row", got.trow, want.trow);
                if (got.color !== want.color) report_mismatch("color", got.color, want.color);
                if (got.pix_wr !== want.pix_wr) report_mismatch("write", got.pix_wr, want.pix_wr);
            end
        end
    end

    initial begin
        #20ms;
        $display("FAIL billboard_sprite_projector_core");
        $finish;
    end

    initial begin
        camera_reset();
        foreach (tex_valid[i]) tex_valid[i] = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_defaults();
        test_directed();
        test_random_cameras();
        test_no_stalls();
        drain();
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("PASS billboard_sprite_projector_core");
        end else begin
            $display("FAIL billboard_sprite_projector_core");
        end
        $finish;
    end

endmodule
